// ===== rtl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// shared types, codes and character constants of the string to integer parser
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int VALUE_BITS_DEFAULT    = 64;
  localparam int POSITION_BITS_DEFAULT = 16;

  localparam int BASE_W   = 6;
  localparam int DIGIT_W  = 6;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 16;
  localparam int RESULT_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [DIGIT_W-1:0] NO_DIGIT  = 6'd36;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_ZEROX  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } item_t;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] end_offset;
    logic [STATUS_W-1:0] parse_status;
    logic [RESULT_W-1:0] parsed_value;
  } result_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd36;
    if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
    else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 8'd10;
    else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 8'd10;
    return d[DIGIT_W-1:0];
  endfunction

endpackage

// ===== rtl/string_to_integer_parser.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser
// parses a character stream into a 64-bit integer with status and end offset
// ----------------------------------------------------------------------------
// characters arrive on the s_axis channel, one per transaction, with tuser
// marking the first character of a new string. leading whitespace, one sign
// and an optional 0x prefix are taken, then digits in the configured base.
// the first character that is not a digit ends the string and produces one
// transaction on m_axis carrying value, status and end offset.
// the cfg port sets number_base (index 0) and signed_mode (index 1); write
// it only while no string is being parsed. the base is sampled at string start.
// an ending character passes through the input register, then the result
// register holds its result. throughput is one character per cycle unless m_axis
// stalls; the step is one radix multiply-add with overflow check per character.
// when m_axis stalls, the held result keeps its data and the parse core stops;
// s_axis takes at most one more character into the input register, then
// tready stays low until the result is taken.
// reset clears parse state and the result valid flag, base returns to 10 and
// signed mode to on; no result is pending after reset.
// ----------------------------------------------------------------------------
module string_to_integer_parser #(
  parameter int VALUE_BITS    = sip_pkg::VALUE_BITS_DEFAULT,
  parameter int POSITION_BITS = sip_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sip_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // char_code
  input  logic                            s_axis_tuser,  // string_start
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [87:0]                     m_axis_tdata   // parsed_value, parse_status,
                                                         // end_offset, zero fill
);
  import sip_pkg::*;

  cfg_t    cfg;
  item_t   s_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= BASE_RESET;
      cfg.signed_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_BASE: cfg.number_base <= cfg_data[BASE_W-1:0];
        REG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: cfg.signed_mode <= cfg.signed_mode;
      endcase
    end
  end

  assign s_item.char_code    = s_axis_tdata;
  assign s_item.string_start = s_axis_tuser;

  sip_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (s_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  sip_parse_core #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {6'd0, res.end_offset, res.parse_status, res.parsed_value};

endmodule

// ===== rtl/sip_in_stage.sv =====
// ----------------------------------------------------------------------------
// sip_in_stage
// input register between the character stream and the parse core
// ----------------------------------------------------------------------------
module sip_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sip_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output sip_pkg::item_t out_item
);
  import sip_pkg::*;

  logic  valid;
  item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/sip_parse_core.sv =====
// ----------------------------------------------------------------------------
// sip_parse_core
// parse state, one-character step logic and result register
// ----------------------------------------------------------------------------
module sip_parse_core #(
  parameter int VALUE_BITS    = sip_pkg::VALUE_BITS_DEFAULT,
  parameter int POSITION_BITS = sip_pkg::POSITION_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  sip_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  sip_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sip_pkg::result_t out_res
);
  import sip_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int PB = POSITION_BITS;
  localparam int PW = PB + 1;
  localparam int MW = VB + BASE_W;

  logic [2:0]        phase, phase_next;
  logic              neg, neg_next;
  logic [VB-1:0]     acc, acc_next;
  logic [BASE_W-1:0] base, base_next;
  logic              ovf, ovf_next;
  logic [PW-1:0]     pos, pos_next;
  logic              res_valid;
  result_t           res, res_next;
  logic              emit;
  logic              take;

  logic [7:0]         c;
  logic [DIGIT_W-1:0] d;
  logic               is_space;
  logic               do_prefix;
  logic               do_digit;
  logic               had_digits;
  logic               do_finish;
  logic               stepped;
  logic [PW-1:0]      fin_off;
  logic [MW-1:0]      mac;
  logic [VB-1:0]      fin_r;
  logic [VB-1:0]      half;
  logic [VB-1:0]      limit;
  logic [PB-1:0]      off_sat;
  logic [32:0]        off_wide;

  assign in_ready  = !res_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = res_valid;
  assign out_res   = res;

  assign c        = in_item.char_code;
  assign d        = digit_of(c);
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign half     = {1'b1, {(VB-1){1'b0}}};

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    base_next  = base;
    ovf_next   = ovf;
    pos_next   = pos;
    emit       = 1'b0;
    res_next   = res;
    do_prefix  = 1'b0;
    do_digit   = 1'b0;
    had_digits = 1'b0;
    do_finish  = 1'b0;
    stepped    = 1'b1;
    fin_off    = pos;
    mac        = '0;
    fin_r      = '0;
    limit      = '0;
    off_sat    = '0;
    off_wide   = '0;

    if (in_item.string_start) begin
      neg_next  = 1'b0;
      acc_next  = '0;
      ovf_next  = 1'b0;
      pos_next  = '0;
      base_next = cfg.number_base;
      if (cfg.number_base == BASE_ONE || cfg.number_base > BASE_MAX) begin
        base_next  = BASE_AUTO;
        phase_next = PH_IDLE;
        emit       = 1'b1;
        res_next   = '{end_offset: '0, parse_status: ST_INVALID, parsed_value: '0};
        stepped    = 1'b0;
      end else begin
        phase_next = PH_SPACE;
      end
    end else if (phase == PH_IDLE) begin
      stepped = 1'b0;
    end

    if (stepped) begin
      fin_off = pos_next;
      case (phase_next)
        PH_SPACE: begin
          if (is_space) begin
            phase_next = PH_SPACE;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg_next   = (c == CH_MINUS);
            phase_next = PH_SIGNED;
          end else begin
            do_prefix = 1'b1;
          end
        end
        PH_SIGNED: begin
          do_prefix = 1'b1;
        end
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            phase_next = PH_ZEROX;
          end else begin
            if (base_next == BASE_AUTO) base_next = BASE_OCT;
            do_digit   = 1'b1;
            had_digits = 1'b1;
          end
        end
        PH_ZEROX: begin
          if (d < DIGIT_W'(16)) begin
            base_next  = BASE_HEX;
            acc_next   = VB'(d);
            phase_next = PH_DIGITS;
          end else begin
            if (base_next == BASE_AUTO) base_next = BASE_OCT;
            do_finish = 1'b1;
            fin_off   = pos_next - 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit   = 1'b1;
          had_digits = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (do_prefix) begin
        if ((base_next == BASE_AUTO || base_next == BASE_HEX) && c == CH_ZERO) begin
          acc_next   = '0;
          phase_next = PH_ZERO;
        end else begin
          if (base_next == BASE_AUTO) base_next = BASE_DEC;
          do_digit = 1'b1;
        end
      end

      if (do_digit) begin
        if (d >= base_next) begin
          if (!had_digits) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
            res_next   = '{end_offset: '0, parse_status: ST_INVALID, parsed_value: '0};
          end else begin
            do_finish = 1'b1;
          end
        end else begin
          mac = MW'(acc_next) * MW'(base_next) + MW'(d);
          if (|mac[MW-1:VB]) begin
            ovf_next = 1'b1;
          end else if (!ovf_next) begin
            acc_next = mac[VB-1:0];
          end
          phase_next = PH_DIGITS;
        end
      end

      if (do_finish) begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
        off_sat    = fin_off[PB] ? {PB{1'b1}} : fin_off[PB-1:0];
        off_wide   = 33'(off_sat);
        res_next.end_offset = (off_wide > 33'd65535) ? 16'hFFFF : off_wide[15:0];
        fin_r = neg_next ? (VB'(0) - acc_next) : acc_next;
        limit = neg_next ? half : (half - 1'b1);
        if (ovf_next || (cfg.signed_mode && acc_next > limit)) begin
          res_next.parse_status = ST_RANGE;
          res_next.parsed_value = '0;
        end else begin
          res_next.parse_status = ST_OK;
          res_next.parsed_value = cfg.signed_mode ? RESULT_W'(signed'(fin_r))
                                                  : RESULT_W'(fin_r);
        end
      end

      if (!pos_next[PB]) pos_next = pos_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      neg       <= 1'b0;
      acc       <= '0;
      base      <= '0;
      ovf       <= 1'b0;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        neg   <= neg_next;
        acc   <= acc_next;
        base  <= base_next;
        ovf   <= ovf_next;
        pos   <= pos_next;
      end
      if (in_ready) begin
        res_valid <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.parse_status == ST_INVALID |->
      res.parsed_value == '0 && res.end_offset == '0)
    else $error("invalid result carries data");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.parse_status == ST_RANGE |-> res.parsed_value == '0)
    else $error("out of range result carries a value");

  a_idle_ignored: assert property (@(posedge clk) disable iff (rst)
    take && !in_item.string_start && phase == PH_IDLE |=> !res_valid)
    else $error("result from a character outside any string");

  a_bad_base: assert property (@(posedge clk) disable iff (rst)
    take && in_item.string_start &&
    (cfg.number_base == BASE_ONE || cfg.number_base > BASE_MAX) |=>
      res_valid && res.parse_status == ST_INVALID && phase == PH_IDLE)
    else $error("bad base not rejected on string start");

endmodule
